// ----- src/internet_checksum_pseudo_header_core_assert.svh -----
// ---------------------------------------------------------------------------
// checksum core assertion macros
// shared concurrent assertion forms, synchronous reset disables checking
// ---------------------------------------------------------------------------
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_CORE_ASSERT_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_CORE_ASSERT_SVH

// same-cycle implication
`define ICPH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("checksum core assertion failed");

// next-cycle implication
`define ICPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("checksum core assertion failed");

`endif

// ----- src/icph_pkg.sv -----
// ---------------------------------------------------------------------------
// checksum core package
// item types, checksum kind codes and pseudo-header constants
// ---------------------------------------------------------------------------
package icph_pkg;

   localparam int COUNT_W    = 17;
   localparam int ACC_W      = 32;

   // checksum kind codes, kind three behaves like plain ip
   localparam logic [1:0] KIND_IP    = 2'd0;
   localparam logic [1:0] KIND_UDP   = 2'd1;
   localparam logic [1:0] KIND_TCP   = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [COUNT_W-1:0] UDP_PROTOCOL      = COUNT_W'(17);
   localparam logic [COUNT_W-1:0] TCP_PROTOCOL      = COUNT_W'(6);
   localparam logic [COUNT_W-1:0] PSEUDO_ADDR_BYTES = COUNT_W'(8);

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] kind;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [15:0] checksum_value;
      logic        length_error;
   } rsp_type;

endpackage

// ----- src/internet_checksum_pseudo_header_core.sv -----
// ---------------------------------------------------------------------------
// internet checksum core with udp/tcp pseudo-header terms
// streams a byte region and returns the ones' complement checksum
// ---------------------------------------------------------------------------
// usage
//   req channel: one byte per item with kind, first and last marks; an item
//   is taken when req_valid is high and req_stall is low
//   rsp channel: one result item per region, sent after the item marked
//   last; taken when rsp_valid is high and rsp_stall is low
//   bytes pair big-endian into words, an odd tail byte gets a zero low byte
//   for udp/tcp the stream leads with source and destination address and the
//   protocol number plus byte count minus 8 are added to the sum
// timing
//   one item per cycle unless req_stall is high; the byte state register
//   updates in one 32-bit add per item
//   the last byte passes the input register, then the sum register, then
//   fold and invert into the result register, which drives rsp_valid
// reset and stall
//   reset empties all stages and clears sum, count, pending byte and kind
//   a stalled result holds in the output register while one more result
//   waits in the sum stage; byte items keep flowing until a second last
//   item meets a full sum stage, then req_stall rises
// ---------------------------------------------------------------------------
module internet_checksum_pseudo_header_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  icph_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output icph_pkg::rsp_type rsp_payload
);
   import icph_pkg::*;

   `include "internet_checksum_pseudo_header_core_assert.svh"

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;

   // region state
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]         held_ff, held_in;
   logic               odd_ff, odd_in;
   logic [1:0]         mode_ff, mode_in;

   // sum stage, one finished region waiting for the fold
   logic               pend_valid_ff, pend_valid_in;
   logic [ACC_W-1:0]   pend_sum_ff, pend_sum_in;
   logic [COUNT_W-1:0] pend_extra_ff, pend_extra_in;
   logic               pend_err_ff, pend_err_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic out_ready, pend_ready, in_fire, in_ready;

   // working values
   logic [ACC_W-1:0]   acc_base, addend, acc_sum, total;
   logic [COUNT_W-1:0] cnt_base, cnt_next, proto;
   logic [7:0]         held_base;
   logic               odd_base, counting, pseudo, err;
   logic [1:0]         mode_base;
   logic [16:0]        fold1;
   logic [15:0]        fold2;

   // handshake chain
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign pend_ready = !pend_valid_ff || out_ready;
   assign in_fire    = in_valid_ff && (!in_ff.last || pend_ready);
   assign in_ready   = !in_valid_ff || in_fire;
   assign req_stall  = !in_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (in_ready) begin
         in_valid_in = req_valid;
         in_in       = req_payload;
      end
   end

   // byte accumulation and region close
   always_comb begin
      // a first mark starts from an empty region
      if (in_ff.first) begin
         acc_base  = '0;
         cnt_base  = '0;
         held_base = '0;
         odd_base  = 1'b0;
         mode_base = in_ff.kind;
      end else begin
         acc_base  = acc_ff;
         cnt_base  = cnt_ff;
         held_base = held_ff;
         odd_base  = odd_ff;
         mode_base = mode_ff;
      end

      // bytes past the saturated count are dropped
      counting = !cnt_base[COUNT_W-1];
      cnt_next = counting ? cnt_base + COUNT_W'(1) : cnt_base;

      // completed word, or the padded tail word when the region closes here
      if (counting) begin
         addend = odd_base ? {16'h0000, held_base, in_ff.data_byte}
                           : {16'h0000, in_ff.data_byte, 8'h00};
      end else begin
         addend = odd_base ? {16'h0000, held_base, 8'h00} : '0;
      end
      acc_sum = acc_base + addend;

      pseudo = (mode_base == KIND_UDP) || (mode_base == KIND_TCP);
      err    = cnt_next[COUNT_W-1] || (pseudo && (cnt_next < PSEUDO_ADDR_BYTES));
      proto  = (mode_base == KIND_UDP) ? UDP_PROTOCOL : TCP_PROTOCOL;

      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      held_in       = held_ff;
      odd_in        = odd_ff;
      mode_in       = mode_ff;
      pend_valid_in = pend_valid_ff;
      pend_sum_in   = pend_sum_ff;
      pend_extra_in = pend_extra_ff;
      pend_err_in   = pend_err_ff;

      if (pend_ready) begin
         pend_valid_in = in_fire && in_ff.last;
      end

      if (in_fire) begin
         mode_in = mode_base;
         if (in_ff.last) begin
            acc_in        = '0;
            cnt_in        = '0;
            held_in       = '0;
            odd_in        = 1'b0;
            pend_sum_in   = acc_sum;
            pend_err_in   = err;
            pend_extra_in = (pseudo && !err) ? proto + (cnt_next - PSEUDO_ADDR_BYTES) : '0;
         end else begin
            cnt_in = cnt_next;
            if (counting && odd_base) begin
               acc_in  = acc_sum;
               held_in = '0;
               odd_in  = 1'b0;
            end else if (counting) begin
               acc_in  = acc_base;
               held_in = in_ff.data_byte;
               odd_in  = 1'b1;
            end else begin
               acc_in  = acc_base;
               held_in = held_base;
               odd_in  = odd_base;
            end
         end
      end
   end

   // pseudo term add, fold to 16 bits and invert
   always_comb begin
      total = pend_sum_ff + {{(ACC_W-COUNT_W){1'b0}}, pend_extra_ff};
      fold1 = {1'b0, total[15:0]} + {1'b0, total[31:16]};
      fold2 = fold1[15:0] + {15'h0000, fold1[16]};

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in                = pend_valid_ff;
         rsp_in.length_error         = pend_err_ff;
         rsp_in.checksum_value       = pend_err_ff ? 16'h0000 : ~fold2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         acc_ff        <= '0;
         cnt_ff        <= '0;
         held_ff       <= '0;
         odd_ff        <= 1'b0;
         mode_ff       <= KIND_IP;
      end else begin
         in_valid_ff   <= in_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_ff        <= acc_in;
         cnt_ff        <= cnt_in;
         held_ff       <= held_in;
         odd_ff        <= odd_in;
         mode_ff       <= mode_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff         <= in_in;
      pend_sum_ff   <= pend_sum_in;
      pend_extra_ff <= pend_extra_in;
      pend_err_ff   <= pend_err_in;
      rsp_ff        <= rsp_in;
   end

   // an error result never carries a checksum
   `ICPH_ASSERT_NOW(a_err_zero, clock, reset,
      rsp_valid_ff && rsp_ff.length_error, rsp_ff.checksum_value == 16'h0000)
   // byte count saturates at 65536 exactly
   `ICPH_ASSERT_NOW(a_cnt_sat, clock, reset, cnt_ff[COUNT_W-1], cnt_ff[COUNT_W-2:0] == '0)
   // no stale high byte without a pending flag
   `ICPH_ASSERT_NOW(a_held_clear, clock, reset, !odd_ff, held_ff == 8'h00)
   // closing a region leaves the state empty
   `ICPH_ASSERT_NEXT(a_region_clear, clock, reset, in_fire && in_ff.last,
      (cnt_ff == '0) && !odd_ff && (acc_ff == '0) && pend_valid_ff)
   // a waiting region result is not lost under output stall
   `ICPH_ASSERT_NEXT(a_pend_hold, clock, reset, pend_valid_ff && !out_ready,
      pend_valid_ff && $stable(pend_sum_ff))

endmodule

// ----- dv/internet_checksum_pseudo_header_core_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// checksum core testbench
// drives byte regions of every kind through the core, predicts each
// ones' complement checksum and length flag, and checks results in order
// ---------------------------------------------------------------------------
module internet_checksum_pseudo_header_core_tb;
   import icph_pkg::*;

   localparam int COUNT_LIMIT = 65536;
   localparam int HOLD_CYCLES = 80;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // predictor state, one copy of the core's running region
   logic [31:0]        run_sum;
   logic [COUNT_W-1:0] run_count;
   logic [7:0]         held_byte;
   bit                 half_held;
   logic [1:0]         run_kind;

   rsp_type pending_sums[$];
   rsp_type wanted_rsp;

   int idle_pct;
   int stall_pct;
   int hold_request;
   int hold_left;
   int mismatch_count;
   int bytes_sent;
   int checksums_seen;
   int length_errors_seen;

   internet_checksum_pseudo_header_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void clear_run();
      run_sum   = '0;
      run_count = '0;
      held_byte = '0;
      half_held = 1'b0;
   endfunction

   // advances the predicted region by one byte; returns 1 when a checksum is due
   function automatic bit predict_checksum(input req_type item, output rsp_type result);
      logic [31:0] total;
      bit          pseudo;
      bit          err;
      result = '0;
      if (item.first) begin
         clear_run();
         run_kind = item.kind;
      end
      // bytes past the count limit are dropped until the region closes
      if (run_count < COUNT_LIMIT) begin
         if (half_held) begin
            run_sum   = run_sum + {16'h0000, held_byte, item.data_byte};
            half_held = 1'b0;
            held_byte = '0;
         end else begin
            held_byte = item.data_byte;
            half_held = 1'b1;
         end
         run_count = run_count + COUNT_W'(1);
      end
      if (!item.last) return 1'b0;

      total = run_sum;
      // odd tail byte gets a zero low byte
      if (half_held) total = total + {16'h0000, held_byte, 8'h00};
      pseudo = (run_kind == KIND_UDP) || (run_kind == KIND_TCP);
      err = (run_count >= COUNT_LIMIT) || (pseudo && run_count < PSEUDO_ADDR_BYTES);
      if (!err && pseudo) begin
         total = total + ((run_kind == KIND_UDP) ? 32'(UDP_PROTOCOL) : 32'(TCP_PROTOCOL));
         total = total + 32'(run_count) - 32'(PSEUDO_ADDR_BYTES);
      end
      total = {16'h0000, total[15:0]} + {16'h0000, total[31:16]};
      total = {16'h0000, total[15:0]} + {16'h0000, total[31:16]};
      result.checksum_value = err ? 16'h0000 : ~total[15:0];
      result.length_error   = err;
      clear_run();
      return 1'b1;
   endfunction

   // offers one byte item, waits for it to be taken, then maybe idles
   task automatic send_byte(input logic [7:0] data, input logic [1:0] kind,
                            input bit first_mark, input bit last_mark);
      req_type item;
      rsp_type expected;
      item.data_byte = data;
      item.kind      = kind;
      item.first     = first_mark;
      item.last      = last_mark;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (predict_checksum(item, expected)) pending_sums.push_back(expected);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // kind rides on every byte but only the first-marked one should latch it
   task automatic send_region(input logic [1:0] kind, input int len, input bit first_mark,
                              input bit close, input bit use_fill, input logic [7:0] fill);
      logic [7:0] data;
      logic [1:0] byte_kind;
      for (int i = 0; i < len; i++) begin
         data      = use_fill ? fill : 8'($urandom_range(255));
         byte_kind = (i == 0) ? kind : 2'($urandom_range(3));
         send_byte(data, byte_kind, first_mark && (i == 0), close && (i == len - 1));
      end
   endtask

   // bytes with no first mark straight after reset, kind stays plain ip
   task automatic test_after_reset();
      send_region(KIND_UDP, 3, 1'b0, 1'b1, 1'b0, 8'h00);
   endtask

   // all-ones and all-zeros data, single byte regions, minimum and short lengths
   task automatic test_extremes();
      send_region(KIND_IP, 4, 1'b1, 1'b1, 1'b1, 8'hFF);
      send_region(KIND_UDP, 8, 1'b1, 1'b1, 1'b1, 8'h00);
      send_region(KIND_IP, 1, 1'b1, 1'b1, 1'b1, 8'hFF);
      send_region(KIND_TCP, 1, 1'b1, 1'b1, 1'b1, 8'h80);
      send_region(KIND_TCP, 2, 1'b1, 1'b1, 1'b0, 8'h00);
   endtask

   // tcp and the unused code, which has no pseudo-header
   task automatic test_kinds();
      send_region(KIND_TCP, 9, 1'b1, 1'b1, 1'b0, 8'h00);
      send_region(KIND_SPARE, 3, 1'b1, 1'b1, 1'b0, 8'h00);
   endtask

   // unmarked region keeps the last kind; a new first mark drops a partial sum
   task automatic test_continuation();
      send_region(KIND_UDP, 10, 1'b1, 1'b1, 1'b0, 8'h00);
      send_region(KIND_IP, 7, 1'b0, 1'b1, 1'b0, 8'h00);
      send_region(KIND_IP, 3, 1'b1, 1'b0, 1'b0, 8'h00);
      send_region(KIND_UDP, 9, 1'b1, 1'b1, 1'b0, 8'h00);
   endtask

   // long odd and even regions with a carry-heavy all-ones one
   task automatic test_long_regions();
      send_region(KIND_IP, 151, 1'b1, 1'b1, 1'b1, 8'hFF);
      send_region(KIND_UDP, 150, 1'b1, 1'b1, 1'b0, 8'h00);
   endtask

   // receiver holds off while short regions keep arriving, input must back up
   task automatic test_backpressure();
      idle_pct     = 0;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 12; i++)
         send_region(2'($urandom_range(3)), 3, 1'b1, 1'b1, 1'b0, 8'h00);
      idle_pct = 18;
   endtask

   // mostly well-formed regions with random content, some broken ones and noise
   task automatic test_random_regions();
      int         sent;
      int         len;
      int         roll;
      logic [1:0] kind;
      bit         marked;
      sent = 0;
      // first stretch runs with no idling on either side
      idle_pct  = 0;
      stall_pct = 0;
      while (sent < 700) begin
         if (sent >= 250) begin
            idle_pct  = 18;
            stall_pct = 18;
         end
         roll   = $urandom_range(99);
         kind   = 2'($urandom_range(3));
         marked = ($urandom_range(99) < 90);
         if (roll < 5) begin
            // lone item with random marks
            send_byte(8'($urandom_range(255)), kind, 1'($urandom), 1'($urandom));
            sent++;
         end else if (roll < 11) begin
            // region abandoned before its last byte
            len = $urandom_range(1, 6);
            send_region(kind, len, marked, 1'b0, 1'b0, 8'h00);
            sent += len;
         end else begin
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 90);
            send_region(kind, len, marked, 1'b1, 1'b0, 8'h00);
            sent += len;
         end
      end
   endtask

   // receiver stall, with a counted hold-off when a test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // result checker, compares every taken result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("result %h/%b with nothing expected",
                                      rsp_payload.checksum_value, rsp_payload.length_error));
         end else begin
            wanted_rsp = pending_sums.pop_front();
            checksums_seen++;
            if (wanted_rsp.length_error) length_errors_seen++;
            if (rsp_payload.checksum_value !== wanted_rsp.checksum_value)
               report_mismatch($sformatf("checksum_value got %h want %h",
                                         rsp_payload.checksum_value, wanted_rsp.checksum_value));
            if (rsp_payload.length_error !== wanted_rsp.length_error)
               report_mismatch($sformatf("length_error got %b want %b",
                                         rsp_payload.length_error, wanted_rsp.length_error));
         end
      end
   end

   // hard stop well past the slowest correct run
   initial begin
      #20_000_000;
      $display("internet_checksum_pseudo_header_core_tb failed");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_payload        = '0;
      idle_pct           = 18;
      stall_pct          = 18;
      hold_request       = 0;
      hold_left          = 0;
      mismatch_count     = 0;
      bytes_sent         = 0;
      checksums_seen     = 0;
      length_errors_seen = 0;
      run_kind           = KIND_IP;
      clear_run();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_extremes();
      test_kinds();
      test_continuation();
      test_backpressure();
      test_long_regions();
      test_random_regions();

      // drain: every prediction must come back, then idle before the report
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d byte items and %0d checksums, %0d of them flagged for length",
               bytes_sent, checksums_seen, length_errors_seen);
      if (mismatch_count == 0)
         $display("internet_checksum_pseudo_header_core_tb passed");
      else
         $display("internet_checksum_pseudo_header_core_tb failed");
      $finish;
   end

endmodule
